/* src/elf_table_layout_checker_core_assert.svh */
// Assertion macros shared by the table layout checker modules.
`ifndef ELF_TABLE_LAYOUT_CHECKER_CORE_ASSERT_SVH
`define ELF_TABLE_LAYOUT_CHECKER_CORE_ASSERT_SVH
// Clocked implication checked outside of reset.
`define ETLC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Clocked implication, consequent checked in the next cycle.
`define ETLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* src/etlc_pkg.sv */
// Shared types and constants of the ELF64 table layout checker.
package etlc_pkg;
    localparam logic [63:0] EHDR_SIZE    = 64'd64;
    localparam logic [31:0] SEG_LOADABLE = 32'd1;

    localparam logic [3:0] ERR_OK         = 4'd0;
    localparam logic [3:0] ERR_SMALL      = 4'd1;
    localparam logic [3:0] ERR_PH_SIZE    = 4'd2;
    localparam logic [3:0] ERR_PH_RANGE   = 4'd3;
    localparam logic [3:0] ERR_CONGRUENCE = 4'd4;
    localparam logic [3:0] ERR_SH_SIZE    = 4'd5;
    localparam logic [3:0] ERR_SH_ZERO    = 4'd6;
    localparam logic [3:0] ERR_SH_ALIGN   = 4'd7;
    localparam logic [3:0] ERR_SH_RANGE   = 4'd8;

    localparam int QDEPTH = 2;

    // Classified work handed from the front end to the back end.
    typedef struct packed {
        logic        emit_now;   // header verdict known, emit directly
        logic        is_header;  // header; starts a check unless emit_now
        logic [3:0]  code;
        logic [15:0] count;
        logic [63:0] off;
        logic [63:0] vaddr;
        logic [63:0] align;
        logic        check_mod;  // loadable entry with alignment above one
    } work_t;

    // True when a table of count*esize bytes at off does not fit in size.
    function automatic logic table_outside(input logic [63:0] size, input logic [63:0] off,
                                           input logic [15:0] count,
                                           input logic [15:0] esize);
        logic [31:0] bytes;
        begin
            bytes = count * esize;
            table_outside = (off > size) || ({32'd0, bytes} > (size - off));
        end
    endfunction
endpackage

/* src/etlc_front.sv */
// Front end: accepts items, classifies headers and entries, feeds the queue.
`include "elf_table_layout_checker_core_assert.svh"
module etlc_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 kind,
    input  logic [63:0]          file_size,
    input  logic [15:0]          ph_count,
    input  logic [15:0]          ph_entry_size,
    input  logic [63:0]          ph_offset,
    input  logic [15:0]          sh_count,
    input  logic [15:0]          sh_entry_size,
    input  logic [63:0]          sh_offset,
    input  logic [31:0]          seg_type,
    input  logic [63:0]          seg_file_offset,
    input  logic [63:0]          seg_vaddr,
    input  logic [63:0]          seg_align,
    output logic                 q_valid,
    input  logic                 q_pop,
    output etlc_pkg::work_t      q_head
);
    etlc_pkg::work_t q_reg [etlc_pkg::QDEPTH];
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_reg, wr_reg;
    etlc_pkg::work_t w;
    logic [3:0] sv;
    logic push;

    always_comb
    begin
        sv = etlc_pkg::ERR_OK;
        if (sh_count != 16'd0)
        begin
            if (sh_entry_size == 16'd0)
                sv = etlc_pkg::ERR_SH_SIZE;
            else if (sh_offset == 64'd0)
                sv = etlc_pkg::ERR_SH_ZERO;
            else if (sh_offset[2:0] != 3'd0)
                sv = etlc_pkg::ERR_SH_ALIGN;
            else if (etlc_pkg::table_outside(file_size, sh_offset, sh_count, sh_entry_size))
                sv = etlc_pkg::ERR_SH_RANGE;
        end
        w = '0;
        w.count = ph_count;
        w.off   = seg_file_offset;
        w.vaddr = seg_vaddr;
        w.align = seg_align;
        w.check_mod = (seg_type == etlc_pkg::SEG_LOADABLE) && (seg_align > 64'd1);
        if (!kind)
        begin
            w.is_header = 1'b1;
            w.code = sv;
            w.emit_now = 1'b1;
            if (file_size < etlc_pkg::EHDR_SIZE)
                w.code = etlc_pkg::ERR_SMALL;
            else if (ph_count == 16'd0)
                w.code = sv;
            else if (ph_entry_size == 16'd0)
                w.code = etlc_pkg::ERR_PH_SIZE;
            else if (etlc_pkg::table_outside(file_size, ph_offset, ph_count, ph_entry_size))
                w.code = etlc_pkg::ERR_PH_RANGE;
            else
                w.emit_now = 1'b0;
        end
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign push = in_valid && in_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_head = q_reg[rd_reg];
    always_comb
    begin
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg <= 1'b0;
            wr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_reg <= ~wr_reg;
            if (q_pop)
                rd_reg <= ~rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_reg] <= w;
    end

    `ETLC_ASSERT_IMP(a_no_overflow, clk, rst_n, cnt_reg == 2'd2, !push)
    `ETLC_ASSERT_IMP(a_no_underflow, clk, rst_n, cnt_reg == 2'd0, !q_pop)
    `ETLC_ASSERT_NEXT(a_cnt_track, clk, rst_n, push && !q_pop && cnt_reg == 2'd0,
                      cnt_reg == 2'd1)
endmodule

/* src/etlc_back.sv */
// Back end: entry sequencing, shared remainder unit and result register.
`include "elf_table_layout_checker_core_assert.svh"
module etlc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_pop,
    input  etlc_pkg::work_t      q_head,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [3:0]           error_code,
    output logic [15:0]          failing_entry
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_CMP  = 2'd2;

    logic [1:0]  st_reg, st_next;
    logic        chk_reg;
    logic [15:0] left_reg, idx_reg;
    logic [3:0]  psv_reg;
    logic [63:0] na_reg, nb_reg, d_reg;
    logic [64:0] ra_reg, rb_reg;
    logic [6:0]  bit_reg;
    logic        ov_reg;
    logic [3:0]  oc_reg;
    logic [15:0] oi_reg;
    logic        can_emit;
    logic        same;
    logic        fire;
    logic [64:0] ta, tb;

    assign out_valid = ov_reg;
    assign error_code = oc_reg;
    assign failing_entry = oi_reg;
    assign can_emit = !ov_reg || out_ready;
    assign same = (ra_reg == rb_reg);
    // Headers and trivial entries retire in IDLE; a congruence test holds the head
    // until its compare step.
    assign q_pop = ((st_reg == ST_IDLE) && q_valid && can_emit &&
                    (q_head.is_header || !chk_reg || !q_head.check_mod)) ||
                   ((st_reg == ST_CMP) && can_emit);
    assign fire = (q_pop && q_head.is_header && q_head.emit_now) ||
                  (q_pop && !q_head.is_header && chk_reg && (st_reg == ST_IDLE || same) &&
                   left_reg == 16'd1) ||
                  ((st_reg == ST_CMP) && can_emit && !same);
    assign ta = {ra_reg[63:0], na_reg[63]};
    assign tb = {rb_reg[63:0], nb_reg[63]};

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE:
                if (q_valid && can_emit && !q_head.is_header && chk_reg && q_head.check_mod)
                    st_next = ST_DIV;
            ST_DIV:
                if (bit_reg == 7'd63)
                    st_next = ST_CMP;
            ST_CMP:
                if (can_emit)
                    st_next = ST_IDLE;
            default:
                st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            chk_reg <= 1'b0;
            left_reg <= 16'd0;
            idx_reg <= 16'd0;
            psv_reg <= 4'd0;
            ov_reg <= 1'b0;
            bit_reg <= 7'd0;
        end
        else
        begin
            st_reg <= st_next;
            if (fire)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
            if (q_pop && q_head.is_header)
            begin
                idx_reg <= 16'd0;
                left_reg <= q_head.count;
                psv_reg <= q_head.code;
                chk_reg <= !q_head.emit_now;
            end
            else if (q_pop && chk_reg && (st_reg == ST_IDLE || same))
            begin
                idx_reg <= idx_reg + 16'd1;
                left_reg <= left_reg - 16'd1;
                if (left_reg == 16'd1)
                    chk_reg <= 1'b0;
            end
            else if (st_reg == ST_CMP && can_emit)
                chk_reg <= 1'b0;
            if (st_reg == ST_IDLE)
                bit_reg <= 7'd0;
            else if (st_reg == ST_DIV)
                bit_reg <= bit_reg + 7'd1;
        end
    end

    // One restoring step per cycle on both dividends against a shared divisor.
    always_ff @(posedge clk)
    begin
        if (st_reg == ST_IDLE)
        begin
            na_reg <= q_head.off;
            nb_reg <= q_head.vaddr;
            d_reg <= q_head.align;
            ra_reg <= '0;
            rb_reg <= '0;
        end
        else if (st_reg == ST_DIV)
        begin
            na_reg <= {na_reg[62:0], 1'b0};
            nb_reg <= {nb_reg[62:0], 1'b0};
            ra_reg <= (ta >= {1'b0, d_reg}) ? ta - {1'b0, d_reg} : ta;
            rb_reg <= (tb >= {1'b0, d_reg}) ? tb - {1'b0, d_reg} : tb;
        end
        if (q_pop && q_head.is_header && q_head.emit_now)
        begin
            oc_reg <= q_head.code;
            oi_reg <= 16'd0;
        end
        else if (st_reg == ST_CMP && can_emit)
        begin
            oc_reg <= same ? psv_reg : etlc_pkg::ERR_CONGRUENCE;
            oi_reg <= same ? 16'd0 : idx_reg;
        end
        else if (q_pop && chk_reg && left_reg == 16'd1)
        begin
            oc_reg <= psv_reg;
            oi_reg <= 16'd0;
        end
    end

    `ETLC_ASSERT_IMP(a_div_needs_check, clk, rst_n, st_reg != ST_IDLE, chk_reg)
    `ETLC_ASSERT_IMP(a_no_pop_busy, clk, rst_n, st_reg == ST_DIV, !q_pop)
    `ETLC_ASSERT_NEXT(a_out_hold, clk, rst_n, ov_reg && !out_ready, ov_reg)
endmodule

/* src/elf_table_layout_checker_core.sv */
// Top level of the ELF64 table layout checker.
// Input channel (in_valid/in_ready) takes header items (kind 0) and program
// header entry items (kind 1); output channel (out_valid/out_ready) gives one
// verdict per checked image: error_code and failing_entry.
// A header is classified in the front end as it is accepted; when it needs no
// entries its verdict goes via the queue to the output register.
// Each loadable entry with alignment above one is loaded in IDLE, then the
// restoring divider forms both remainders one bit a cycle, and CMP compares
// them. Other entries retire directly from IDLE.
// A two-entry queue sits between the front end and the back end, so input
// is taken while the divider works or while a verdict waits.
// If the receiver stalls, the verdict is held in the output register and the
// back end stops popping; the queue then fills and in_ready drops.
// Reset clears the queue, any check in progress and the output valid.
// Entries with no check in progress are accepted and produce nothing.
module elf_table_layout_checker_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [63:0] file_size,
    input  logic [15:0] ph_count,
    input  logic [15:0] ph_entry_size,
    input  logic [63:0] ph_offset,
    input  logic [15:0] sh_count,
    input  logic [15:0] sh_entry_size,
    input  logic [63:0] sh_offset,
    input  logic [31:0] seg_type,
    input  logic [63:0] seg_file_offset,
    input  logic [63:0] seg_vaddr,
    input  logic [63:0] seg_align,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  error_code,
    output logic [15:0] failing_entry
);
    logic            q_valid, q_pop;
    etlc_pkg::work_t q_head;

    etlc_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .file_size(file_size), .ph_count(ph_count),
        .ph_entry_size(ph_entry_size), .ph_offset(ph_offset), .sh_count(sh_count),
        .sh_entry_size(sh_entry_size), .sh_offset(sh_offset), .seg_type(seg_type),
        .seg_file_offset(seg_file_offset), .seg_vaddr(seg_vaddr),
        .seg_align(seg_align), .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head)
    );

    etlc_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head),
        .out_valid(out_valid), .out_ready(out_ready), .error_code(error_code),
        .failing_entry(failing_entry)
    );
endmodule
